### rtl/osm_pkg.sv
// shared types, codes and constants for the one-shot modifier state machine
package osm_pkg;

    localparam int KeyW  = 16;
    localparam int TimeW = 16;
    localparam int CfgW  = 16;
    localparam int CfgIdxW = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_TRIGGER_KEYCODE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ACTIVE_TIMEOUT  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_TIMEOUT  = 2'd2;

    localparam logic [KeyW-1:0]  TRIGGER_KEYCODE_RST = 16'd0;
    localparam logic [TimeW-1:0] ACTIVE_TIMEOUT_RST  = 16'd500;
    localparam logic [TimeW-1:0] UNUSED_TIMEOUT_RST  = 16'd300;

    // request kinds
    localparam logic [1:0] REQ_KEY_EVENT    = 2'd0;
    localparam logic [1:0] REQ_SCAN_TICK    = 2'd1;
    localparam logic [1:0] REQ_FORCE_CANCEL = 2'd2;

    // actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_ENGAGE  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // externally visible mode codes
    localparam logic [2:0] MODE_CODE_UP_UNQUEUED    = 3'd0;
    localparam logic [2:0] MODE_CODE_DOWN_UNUSED    = 3'd1;
    localparam logic [2:0] MODE_CODE_DOWN_USED      = 3'd2;
    localparam logic [2:0] MODE_CODE_UP_QUEUED      = 3'd3;
    localparam logic [2:0] MODE_CODE_UP_QUEUED_USED = 3'd4;

    typedef enum logic [4:0] {
        MODE_UP_UNQUEUED    = 5'b00001,
        MODE_DOWN_UNUSED    = 5'b00010,
        MODE_DOWN_USED      = 5'b00100,
        MODE_UP_QUEUED      = 5'b01000,
        MODE_UP_QUEUED_USED = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KeyW-1:0]  keycode;
        logic             is_press;
        logic             is_cancel_key;
        logic             is_ignored_key;
        logic [TimeW-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] mode_now;
    } out_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        c = MODE_CODE_UP_UNQUEUED;
        unique case (m)
            MODE_UP_UNQUEUED:    c = MODE_CODE_UP_UNQUEUED;
            MODE_DOWN_UNUSED:    c = MODE_CODE_DOWN_UNUSED;
            MODE_DOWN_USED:      c = MODE_CODE_DOWN_USED;
            MODE_UP_QUEUED:      c = MODE_CODE_UP_QUEUED;
            MODE_UP_QUEUED_USED: c = MODE_CODE_UP_QUEUED_USED;
            default:             c = MODE_CODE_UP_UNQUEUED;
        endcase
        return c;
    endfunction

endpackage

### rtl/oneshot_modifier_fsm.sv
// one-shot modifier key state machine with registered result and skid stage
//
// channels: input items arrive on in_valid/in_data and are taken when in_stall
// is low; each item gives exactly one result on out_valid/out_data, taken when
// out_stall is low. configuration is a plain write port (cfg_we, cfg_index,
// cfg_data): index 0 trigger keycode, 1 active timeout, 2 unused timeout.
// the mode and stamps update at the accepting edge, where the result is
// written to the result register, or to the skid entry if a result still waits.
// items are taken at one item per cycle while in_stall is low.
// a result register plus one skid entry part the two sides: while the result
// waits, one more item is still taken; in_stall rises only when the skid
// entry is occupied, and drops in the cycle after the receiver takes a result.
// reset puts the key up and unqueued, clears both stamps, loads the default
// timeouts (500 and 300 ms) and a trigger keycode of 0, and empties the
// output stages.
module oneshot_modifier_fsm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  osm_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output osm_pkg::out_t                out_data,
    input  logic                         cfg_we,
    input  logic [osm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [osm_pkg::CfgW-1:0]     cfg_data
);

    logic [osm_pkg::KeyW-1:0]  trigger_keycode_reg;
    logic [osm_pkg::TimeW-1:0] active_timeout_reg;
    logic [osm_pkg::TimeW-1:0] unused_timeout_reg;

    osm_pkg::mode_t            mode_reg, mode_next;
    logic [osm_pkg::TimeW-1:0] press_stamp_reg, press_stamp_next;
    logic [osm_pkg::TimeW-1:0] queue_stamp_reg, queue_stamp_next;
    logic [1:0]                act;
    logic [osm_pkg::TimeW-1:0] press_elapsed;
    logic [osm_pkg::TimeW-1:0] queue_elapsed;

    osm_pkg::out_t out_data_reg, skid_data_reg, result;
    logic          out_valid_reg, skid_valid_reg;
    logic          in_accept, out_take;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // wrapped elapsed times
    assign press_elapsed = in_data.now_ms - press_stamp_reg;
    assign queue_elapsed = in_data.now_ms - queue_stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_keycode_reg <= osm_pkg::TRIGGER_KEYCODE_RST;
            active_timeout_reg  <= osm_pkg::ACTIVE_TIMEOUT_RST;
            unused_timeout_reg  <= osm_pkg::UNUSED_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                osm_pkg::CFG_TRIGGER_KEYCODE: trigger_keycode_reg <= cfg_data;
                osm_pkg::CFG_ACTIVE_TIMEOUT:  active_timeout_reg  <= cfg_data;
                osm_pkg::CFG_UNUSED_TIMEOUT:  unused_timeout_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        press_stamp_next = press_stamp_reg;
        queue_stamp_next = queue_stamp_reg;
        act              = osm_pkg::ACT_NONE;
        unique case (in_data.req_type)
            osm_pkg::REQ_KEY_EVENT:
            begin
                if (in_data.keycode == trigger_keycode_reg)
                begin
                    if (in_data.is_press)
                    begin
                        if (mode_reg == osm_pkg::MODE_UP_UNQUEUED)
                            act = osm_pkg::ACT_ENGAGE;
                        mode_next        = osm_pkg::MODE_DOWN_UNUSED;
                        press_stamp_next = in_data.now_ms;
                    end
                    else if (mode_reg == osm_pkg::MODE_DOWN_UNUSED)
                    begin
                        mode_next        = osm_pkg::MODE_UP_QUEUED;
                        queue_stamp_next = in_data.now_ms;
                    end
                    else if (mode_reg == osm_pkg::MODE_DOWN_USED)
                    begin
                        mode_next = osm_pkg::MODE_UP_UNQUEUED;
                        act       = osm_pkg::ACT_RELEASE;
                    end
                end
                else if (in_data.is_press)
                begin
                    // cancel first, then the use step sees the cancelled mode
                    if (in_data.is_cancel_key && (mode_reg == osm_pkg::MODE_UP_QUEUED ||
                                                  mode_reg == osm_pkg::MODE_UP_QUEUED_USED))
                    begin
                        mode_next = osm_pkg::MODE_UP_UNQUEUED;
                        act       = osm_pkg::ACT_RELEASE;
                    end
                    if (!in_data.is_ignored_key)
                    begin
                        if (mode_next == osm_pkg::MODE_DOWN_UNUSED)
                            mode_next = osm_pkg::MODE_DOWN_USED;
                        else if (mode_next == osm_pkg::MODE_UP_QUEUED)
                            mode_next = osm_pkg::MODE_UP_QUEUED_USED;
                        else if (mode_next == osm_pkg::MODE_UP_QUEUED_USED)
                        begin
                            mode_next = osm_pkg::MODE_UP_UNQUEUED;
                            act       = osm_pkg::ACT_RELEASE;
                        end
                    end
                end
                else if (!in_data.is_ignored_key && mode_reg == osm_pkg::MODE_UP_QUEUED_USED)
                begin
                    mode_next = osm_pkg::MODE_UP_UNQUEUED;
                    act       = osm_pkg::ACT_RELEASE;
                end
            end
            osm_pkg::REQ_SCAN_TICK:
            begin
                if (mode_reg == osm_pkg::MODE_UP_QUEUED)
                begin
                    if (queue_elapsed >= active_timeout_reg)
                    begin
                        mode_next        = osm_pkg::MODE_UP_UNQUEUED;
                        queue_stamp_next = '0;
                        act              = osm_pkg::ACT_RELEASE;
                    end
                end
                else if (mode_reg == osm_pkg::MODE_DOWN_UNUSED)
                begin
                    if (press_elapsed >= unused_timeout_reg)
                    begin
                        mode_next        = osm_pkg::MODE_DOWN_USED;
                        press_stamp_next = '0;
                    end
                end
            end
            osm_pkg::REQ_FORCE_CANCEL:
            begin
                if (mode_reg != osm_pkg::MODE_UP_UNQUEUED)
                begin
                    mode_next = osm_pkg::MODE_UP_UNQUEUED;
                    act       = osm_pkg::ACT_RELEASE;
                end
            end
            default: ;
        endcase
        result.action   = act;
        result.mode_now = osm_pkg::mode_code(mode_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= osm_pkg::MODE_UP_UNQUEUED;
            press_stamp_reg <= '0;
            queue_stamp_reg <= '0;
        end
        else if (in_accept)
        begin
            mode_reg        <= mode_next;
            press_stamp_reg <= press_stamp_next;
            queue_stamp_reg <= queue_stamp_next;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    // skid entry is only ever filled behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front");

    // an accepted transaction always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction left no result");

    // engage only comes with the key going down unused
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.action == osm_pkg::ACT_ENGAGE) |->
        (out_data_reg.mode_now == osm_pkg::MODE_CODE_DOWN_UNUSED))
        else $error("engage with wrong mode");

    // release always ends up and unqueued
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.action == osm_pkg::ACT_RELEASE) |->
        (out_data_reg.mode_now == osm_pkg::MODE_CODE_UP_UNQUEUED))
        else $error("release with wrong mode");

    // a stamp changes only on an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(press_stamp_reg) && $stable(queue_stamp_reg)))
        else $error("stamp moved without a transaction");

endmodule

### test/tb.sv
// self-checking testbench for the one-shot modifier key state machine
module tb;

    // request code with no meaning, the block must pass it by
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic          typed;
        logic [1:0]    act;
        logic [2:0]    md;
        osm_pkg::in_t  item;
    } row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    osm_pkg::in_t     in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    osm_pkg::out_t    out_data;
    logic             cfg_we    = 1'b0;
    logic [osm_pkg::CfgIdxW-1:0] cfg_index = osm_pkg::CFG_TRIGGER_KEYCODE;
    logic [osm_pkg::CfgW-1:0]    cfg_data  = '0;

    // expectation typed into the directed table travels alongside the transaction
    logic             row_typed = 1'b0;
    osm_pkg::out_t    row_want  = '0;
    logic             calm      = 1'b0;

    // mirror of the block's configuration and state
    logic [osm_pkg::KeyW-1:0]  trig_key  = osm_pkg::TRIGGER_KEYCODE_RST;
    logic [osm_pkg::TimeW-1:0] active_ms = osm_pkg::ACTIVE_TIMEOUT_RST;
    logic [osm_pkg::TimeW-1:0] unused_ms = osm_pkg::UNUSED_TIMEOUT_RST;
    logic [2:0]                key_mode  = osm_pkg::MODE_CODE_UP_UNQUEUED;
    logic [osm_pkg::TimeW-1:0] press_stamp = '0;
    logic [osm_pkg::TimeW-1:0] queue_stamp = '0;

    logic [osm_pkg::TimeW-1:0] wall_ms = '0;
    osm_pkg::out_t    awaited_results[$];
    row_t             steps[$];
    int               mismatches = 0;

    oneshot_modifier_fsm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // advances the mirrored key state by one transaction and returns its result
    function automatic osm_pkg::out_t oneshot_step(input osm_pkg::in_t it);
        logic [1:0]                act;
        logic [osm_pkg::TimeW-1:0] since;
        osm_pkg::out_t             res;
        act = osm_pkg::ACT_NONE;
        case (it.req_type)
            osm_pkg::REQ_KEY_EVENT:
            begin
                if (it.keycode == trig_key)
                begin
                    if (it.is_press)
                    begin
                        if (key_mode == osm_pkg::MODE_CODE_UP_UNQUEUED)
                            act = osm_pkg::ACT_ENGAGE;
                        key_mode = osm_pkg::MODE_CODE_DOWN_UNUSED;
                        press_stamp = it.now_ms;
                    end
                    else if (key_mode == osm_pkg::MODE_CODE_DOWN_UNUSED)
                    begin
                        key_mode = osm_pkg::MODE_CODE_UP_QUEUED;
                        queue_stamp = it.now_ms;
                    end
                    else if (key_mode == osm_pkg::MODE_CODE_DOWN_USED)
                    begin
                        key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                        act = osm_pkg::ACT_RELEASE;
                    end
                end
                else if (it.is_press)
                begin
                    if (it.is_cancel_key && (key_mode == osm_pkg::MODE_CODE_UP_QUEUED ||
                                             key_mode == osm_pkg::MODE_CODE_UP_QUEUED_USED))
                    begin
                        key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                        act = osm_pkg::ACT_RELEASE;
                    end
                    if (!it.is_ignored_key)
                    begin
                        if (key_mode == osm_pkg::MODE_CODE_DOWN_UNUSED)
                            key_mode = osm_pkg::MODE_CODE_DOWN_USED;
                        else if (key_mode == osm_pkg::MODE_CODE_UP_QUEUED)
                            key_mode = osm_pkg::MODE_CODE_UP_QUEUED_USED;
                        else if (key_mode == osm_pkg::MODE_CODE_UP_QUEUED_USED)
                        begin
                            key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                            act = osm_pkg::ACT_RELEASE;
                        end
                    end
                end
                else if (!it.is_ignored_key && key_mode == osm_pkg::MODE_CODE_UP_QUEUED_USED)
                begin
                    key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                    act = osm_pkg::ACT_RELEASE;
                end
            end
            osm_pkg::REQ_SCAN_TICK:
            begin
                if (key_mode == osm_pkg::MODE_CODE_UP_QUEUED)
                begin
                    since = it.now_ms - queue_stamp;
                    if (since >= active_ms)
                    begin
                        key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                        queue_stamp = '0;
                        act = osm_pkg::ACT_RELEASE;
                    end
                end
                else if (key_mode == osm_pkg::MODE_CODE_DOWN_UNUSED)
                begin
                    since = it.now_ms - press_stamp;
                    if (since >= unused_ms)
                    begin
                        key_mode = osm_pkg::MODE_CODE_DOWN_USED;
                        press_stamp = '0;
                    end
                end
            end
            osm_pkg::REQ_FORCE_CANCEL:
            begin
                if (key_mode != osm_pkg::MODE_CODE_UP_UNQUEUED)
                begin
                    key_mode = osm_pkg::MODE_CODE_UP_UNQUEUED;
                    act = osm_pkg::ACT_RELEASE;
                end
            end
            default: ;
        endcase
        res.action = act;
        res.mode_now = key_mode;
        return res;
    endfunction

    function automatic row_t row_of(input logic typed, input logic [1:0] act,
                                    input logic [2:0] md, input logic [1:0] req,
                                    input logic [osm_pkg::KeyW-1:0] key, input logic press,
                                    input logic cancel, input logic ign,
                                    input logic [osm_pkg::TimeW-1:0] now);
        row_t r;
        r.typed = typed;
        r.act = act;
        r.md = md;
        r.item.req_type = req;
        r.item.keycode = key;
        r.item.is_press = press;
        r.item.is_cancel_key = cancel;
        r.item.is_ignored_key = ign;
        r.item.now_ms = now;
        return r;
    endfunction

    // random transaction: trigger press/release, other keys, ticks, force cancels and unused codes
    function automatic osm_pkg::in_t random_item();
        osm_pkg::in_t it;
        int  pick;
        int  step;
        it.req_type = osm_pkg::REQ_KEY_EVENT;
        it.keycode = 16'($urandom);
        it.is_press = 1'($urandom);
        it.is_cancel_key = ($urandom_range(0, 3) == 0);
        it.is_ignored_key = ($urandom_range(0, 3) == 0);
        step = $urandom_range(0, 9);
        if (step < 6)
            wall_ms = wall_ms + 16'($urandom_range(0, 150));
        else if (step < 9)
            wall_ms = wall_ms + 16'($urandom_range(0, 700));
        else
            wall_ms = wall_ms + 16'($urandom);
        it.now_ms = ($urandom_range(0, 19) == 0) ? 16'($urandom) : wall_ms;
        pick = $urandom_range(0, 99);
        if (pick < 32)
        begin
            it.keycode = trig_key;
            // releases are more likely while the key is held
            if (key_mode == osm_pkg::MODE_CODE_DOWN_UNUSED ||
                key_mode == osm_pkg::MODE_CODE_DOWN_USED)
                it.is_press = ($urandom_range(0, 3) == 0);
            else
                it.is_press = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 65)
            it.req_type = osm_pkg::REQ_KEY_EVENT;
        else if (pick < 92)
            it.req_type = osm_pkg::REQ_SCAN_TICK;
        else if (pick < 97)
            it.req_type = osm_pkg::REQ_FORCE_CANCEL;
        else
            it.req_type = REQ_UNUSED;
        return it;
    endfunction

    always @(posedge clk)
    begin
        osm_pkg::out_t predicted;
        osm_pkg::out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = oneshot_step(in_data);
                awaited_results.push_back(row_typed ? row_want : predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with none awaited, mode", out_data.mode_now, -1);
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.action !== want.action)
                        report_mismatch("action", out_data.action, want.action);
                    if (out_data.mode_now !== want.mode_now)
                        report_mismatch("mode_now", out_data.mode_now, want.mode_now);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic send_item(input osm_pkg::in_t it, input logic typed,
                             input osm_pkg::out_t want);
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // write enable stays high across the three writes
    task automatic set_config(input logic [osm_pkg::CfgW-1:0] trig,
                              input logic [osm_pkg::CfgW-1:0] act_to,
                              input logic [osm_pkg::CfgW-1:0] unused_to);
        cfg_we <= 1'b1;
        cfg_index <= osm_pkg::CFG_TRIGGER_KEYCODE;
        cfg_data <= trig;
        @(posedge clk);
        trig_key = trig;
        cfg_index <= osm_pkg::CFG_ACTIVE_TIMEOUT;
        cfg_data <= act_to;
        @(posedge clk);
        active_ms = act_to;
        cfg_index <= osm_pkg::CFG_UNUSED_TIMEOUT;
        cfg_data <= unused_to;
        @(posedge clk);
        unused_ms = unused_to;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input logic [osm_pkg::CfgW-1:0] trig,
                             input logic [osm_pkg::CfgW-1:0] act_to,
                             input logic [osm_pkg::CfgW-1:0] unused_to,
                             input logic quiet);
        wait_results();
        set_config(trig, act_to, unused_to);
        calm <= quiet;
        for (int n = 0; n < count; n++)
        begin
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 99) < 4)
                wait_results();
            send_item(random_item(), 1'b0, '0);
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        osm_pkg::out_t want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // trigger keycode is 0 and the timeouts 500 and 300 after reset
        steps.push_back(row_of(1, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_SCAN_TICK, 16'h0000, 0, 0, 0, 16'd0));
        steps.push_back(row_of(1, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_FORCE_CANCEL, 16'h0000, 0, 0, 0, 16'd0));
        steps.push_back(row_of(1, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               REQ_UNUSED, 16'hFFFF, 1, 1, 1, 16'hFFFF));
        steps.push_back(row_of(1, osm_pkg::ACT_ENGAGE, osm_pkg::MODE_CODE_DOWN_UNUSED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'hFFFF));
        // elapsed time wraps past zero: one below and then exactly the unused timeout
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_SCAN_TICK, 16'h0000, 0, 0, 0, 16'd298));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_SCAN_TICK, 16'h0000, 0, 0, 0, 16'd299));
        steps.push_back(row_of(1, osm_pkg::ACT_RELEASE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 0, 0, 0, 16'd400));
        // tap, then the active timeout runs out
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd1000));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 0, 0, 0, 16'd1100));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_SCAN_TICK, 16'h0000, 0, 0, 0, 16'd1599));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_SCAN_TICK, 16'h0000, 0, 0, 0, 16'd1600));
        // held and used by another key, ignored key passes by, press again while used
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd2000));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'hFFFF, 1, 0, 1, 16'd2010));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'hFFFF, 1, 0, 0, 16'd2020));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd2030));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 0, 0, 0, 16'd2100));
        // cancel key while queued
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0005, 1, 1, 0, 16'd2110));
        // queued, used by a press, released by the matching release
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd2200));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 0, 0, 0, 16'd2210));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0007, 1, 0, 0, 16'd2220));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0007, 0, 0, 1, 16'd2230));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0007, 0, 0, 0, 16'd2240));
        // cancel key that is also ignored while queued and used
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd2300));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 0, 0, 0, 16'd2310));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0009, 1, 0, 0, 16'd2320));
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0009, 1, 1, 1, 16'd2330));
        // force cancel of a held key
        steps.push_back(row_of(0, osm_pkg::ACT_NONE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_KEY_EVENT, 16'h0000, 1, 0, 0, 16'd2400));
        steps.push_back(row_of(1, osm_pkg::ACT_RELEASE, osm_pkg::MODE_CODE_UP_UNQUEUED,
                               osm_pkg::REQ_FORCE_CANCEL, 16'h0000, 0, 0, 0, 16'd2410));

        foreach (steps[i])
        begin
            want.action = steps[i].act;
            want.mode_now = steps[i].md;
            send_item(steps[i].item, steps[i].typed, want);
        end

        // timeouts of 1, highest timeouts, zero timeouts, a calm stretch, then defaults
        run_phase(110, 16'hFFFF, 16'd1, 16'd1, 1'b0);
        run_phase(100, 16'($urandom), 16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(80, 16'($urandom), 16'd0, 16'd0, 1'b0);
        run_phase(150, 16'($urandom), 16'($urandom_range(50, 600)),
                  16'($urandom_range(50, 600)), 1'b1);
        run_phase(110, 16'($urandom), osm_pkg::ACTIVE_TIMEOUT_RST,
                  osm_pkg::UNUSED_TIMEOUT_RST, 1'b0);

        wait_results();
        repeat (5) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 0, awaited_results.size());
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
